@@ src/mexp_pkg.sv @@
// Package for the modular exponentiation block.
// Holds the sequencer state type, the multiplier status struct and register indexes.
// No dependencies.
package mexp_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_EXP = 2'd2;

    // Exponentiation sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

@@ src/mexp_in_if.sv @@
// Input channel of the modular exponentiation block: selector and value.
// Depends on nothing.
interface mexp_in_if #(parameter int WIDTH = 16);
    logic             valid;
    logic             ready;
    logic             action;
    logic [WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

@@ src/mexp_out_if.sv @@
// Output channel of the modular exponentiation block: one result per beat.
// Depends on nothing.
interface mexp_out_if #(parameter int WIDTH = 16);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

@@ src/modular_exponentiation.sv @@
// Top level of the modular exponentiation block: configuration registers and sequencer.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if, mexp_seq and mexp_modmul.
//
//  Channel   Dir   Beat contents
//  i_in      in    action (1 bit), value (VALUE_WIDTH bits)
//  o_out     out   result (VALUE_WIDTH bits)
//  i_cfg_*   in    write enable, register index, write data
//
// An item needs no multiplication when the exponent is 0 or 1, or the modulus is 0 or 1.
// Otherwise it takes the initial reduction and then M modular multiplications (up to
// 2 * VALUE_WIDTH - 1), all on the bit-serial multiplier, which handles one bit per
// cycle and then raises done.
// Synchronous active-low reset returns the registers to modulus 2, exponents 1.
// The next item is accepted while a finished result waits on a stalled output; a second
// finished result holds the sequencer until the first one is taken.
module modular_exponentiation import mexp_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [VALUE_WIDTH-1:0] i_cfg_data,
    mexp_in_if.sink                i_in,
    mexp_out_if.source             o_out
);
    logic [VALUE_WIDTH-1:0] r_modulus;
    logic [VALUE_WIDTH-1:0] r_enc_exp;
    logic [VALUE_WIDTH-1:0] r_dec_exp;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= VALUE_WIDTH'(2);
            r_enc_exp <= VALUE_WIDTH'(1);
            r_dec_exp <= VALUE_WIDTH'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:     r_modulus <= i_cfg_data;
                CFG_ENCRYPT_EXP: r_enc_exp <= i_cfg_data;
                CFG_DECRYPT_EXP: r_dec_exp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mexp_seq #(.W(VALUE_WIDTH)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (r_modulus),
        .i_enc_exp (r_enc_exp),
        .i_dec_exp (r_dec_exp),
        .i_in      (i_in),
        .o_out     (o_out)
    );

endmodule

@@ src/mexp_modmul.sv @@
// Shared bit-serial modular multiplier: p = a * b mod m, one bit of a per cycle.
// Depends on mexp_pkg. Requires b < m and m >= 2; a may take any value.
module mexp_modmul import mexp_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output t_mul_stat    o_stat,
    output logic [W-1:0] o_p
);
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [W-1:0]  r_p;
    logic [CW-1:0] r_cnt;

    logic [W:0]    m_ext;
    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W:0]    sum_red;
    logic [W-1:0]  n_p;

    // One step of interleaved multiplication: double, reduce, add, reduce.
    always_comb begin
        m_ext   = {1'b0, r_m};
        dbl     = {r_p, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + {1'b0, (r_a[W-1] ? r_b : {W{1'b0}})};
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
        n_p     = sum_red[W-1:0];
    end

    // Control: busy after a start until the bit counter reaches zero, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operands and partial product.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_p   <= '0;
            r_cnt <= CW'(W - 1);
        end else if (r_busy) begin
            r_a   <= {r_a[W-2:0], 1'b0};
            r_p   <= n_p;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_p         = r_p;

endmodule

@@ src/mexp_seq.sv @@
// Square-and-multiply sequencer with input handshake and output register.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and mexp_modmul.
module mexp_seq import mexp_pkg::*; #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [W-1:0] i_modulus,
    input  logic [W-1:0] i_enc_exp,
    input  logic [W-1:0] i_dec_exp,
    mexp_in_if.sink      i_in,
    mexp_out_if.source   o_out
);
    t_state       r_state;
    t_state       n_state;
    logic [W-1:0] r_e;
    logic [W-1:0] n_e;
    logic [W-1:0] r_acc;
    logic [W-1:0] n_acc;
    logic [W-1:0] r_base;
    logic [W-1:0] n_base;
    logic         r_out_valid;
    logic [W-1:0] r_result;

    logic         mul_start;
    logic [W-1:0] mul_a;
    logic [W-1:0] mul_b;
    logic [W-1:0] mul_p;
    t_mul_stat    mul_stat;
    logic         load_out;
    logic [W-1:0] sel_exp;
    logic [W-1:0] e_shift;

    mexp_modmul #(.W(W)) u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (i_modulus),
        .o_stat  (mul_stat),
        .o_p     (mul_p)
    );

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_result;

    // Next state, multiplier requests and data updates.
    always_comb begin
        n_state   = r_state;
        n_e       = r_e;
        n_acc     = r_acc;
        n_base    = r_base;
        mul_start = 1'b0;
        mul_a     = mul_p;
        mul_b     = mul_p;
        load_out  = 1'b0;
        sel_exp   = i_in.action ? i_dec_exp : i_enc_exp;
        e_shift   = {1'b0, r_e[W-1:1]};
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_acc = i_in.value;
                    n_e   = sel_exp;
                    if ((i_modulus == '0) || (sel_exp[W-1:1] == '0)) begin
                        n_state = S_OUT;
                    end else if (i_modulus == W'(1)) begin
                        n_acc   = '0;
                        n_state = S_OUT;
                    end else begin
                        // Reduce the value first: value * 1 mod m.
                        n_acc     = W'(1);
                        mul_start = 1'b1;
                        mul_a     = i_in.value;
                        mul_b     = W'(1);
                        n_state   = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mul_stat.done) begin
                    n_base    = mul_p;
                    mul_start = 1'b1;
                    if (r_e[0]) begin
                        mul_a   = r_acc;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (mul_stat.done) begin
                    n_acc = mul_p;
                    if (e_shift == '0) begin
                        n_state = S_OUT;
                    end else begin
                        mul_start = 1'b1;
                        mul_a     = r_base;
                        mul_b     = r_base;
                        n_state   = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mul_stat.done) begin
                    // The square retires the low exponent bit.
                    n_base    = mul_p;
                    n_e       = e_shift;
                    mul_start = 1'b1;
                    if (e_shift[0]) begin
                        mul_a   = r_acc;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working values and the result register.
    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_acc  <= n_acc;
        r_base <= n_base;
        if (load_out) begin
            r_result <= r_acc;
        end
    end

    // A multiplier result only arrives while a multiplication is expected.
    a_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> ((r_state == S_RED) || (r_state == S_MUL) || (r_state == S_SQR)))
        else $error("multiplier done outside a multiply state");

    // While waiting on the multiplier it is running or just finished.
    a_mul_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RED) || (r_state == S_MUL) || (r_state == S_SQR))
        |-> (mul_stat.busy || mul_stat.done))
        else $error("sequencer waits on an idle multiplier");

    // The exponent never runs out while squaring or multiplying.
    a_exp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) || (r_state == S_SQR)) |-> (r_e != '0))
        else $error("exponent exhausted during exponentiation");

    // A result that is still waiting stays valid until the receiver takes it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

@@ test/tb_modular_exponentiation.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for modular_exponentiation: directed corner cases, then random traffic.
// Depends on mexp_pkg, mexp_in_if, mexp_out_if and the modular_exponentiation top level.

module tb_modular_exponentiation;
    import mexp_pkg::*;

    localparam int W = 16;
    localparam int RAND_PHASES = 13;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Tracks the register copies and the powers still owed by the block.
    class ModPowChecker;
        logic [W-1:0] modulus;
        logic [W-1:0] enc_exp;
        logic [W-1:0] dec_exp;
        logic [W-1:0] pending_powers[$];
        int errors;

        function new();
            modulus = W'(2);
            enc_exp = W'(1);
            dec_exp = W'(1);
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
            case (idx)
                CFG_MODULUS: modulus = data;
                CFG_ENCRYPT_EXP: enc_exp = data;
                CFG_DECRYPT_EXP: dec_exp = data;
                default: ;
            endcase
        endfunction

        // Square-and-multiply with 32-bit products; exponents of 0 or 1 and a
        // zero modulus pass the value through unreduced.
        function logic [W-1:0] pow_mod(logic [W-1:0] base, logic [W-1:0] expo,
                                       logic [W-1:0] m);
            logic [2*W-1:0] acc;
            logic [2*W-1:0] sq;
            logic [W-1:0] e;
            if (m == 0 || expo <= 1) return base;
            acc = 1 % m;
            sq = {{W{1'b0}}, base % m};
            e = expo;
            while (e != 0) begin
                if (e[0]) acc = (acc * sq) % m;
                sq = (sq * sq) % m;
                e = e >> 1;
            end
            return acc[W-1:0];
        endfunction

        function void note_input(logic act, logic [W-1:0] val);
            pending_powers = {pending_powers, pow_mod(val, act ? dec_exp : enc_exp, modulus)};
        endfunction

        function void check_result(logic [W-1:0] got);
            logic [W-1:0] want;
            if (pending_powers.size() == 0) begin
                $error("result %0d arrived with nothing pending", got);
                errors++;
                return;
            end
            want = pending_powers.pop_front();
            if (got !== want) begin
                $error("result mismatch: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [W-1:0] i_cfg_data;
    int send_idle;
    int recv_idle;

    ModPowChecker board = new();

    mexp_in_if #(.WIDTH(W)) in_if ();
    mexp_out_if #(.WIDTH(W)) out_if ();

    modular_exponentiation #(.VALUE_WIDTH(W)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in(in_if),
        .o_out(out_if)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Every result beat is checked against the oldest pending power.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) board.check_result(out_if.result);
    end

    // Hang guard.
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        board.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_key(logic [W-1:0] m, logic [W-1:0] e, logic [W-1:0] d);
        write_reg(CFG_MODULUS, m);
        write_reg(CFG_ENCRYPT_EXP, e);
        write_reg(CFG_DECRYPT_EXP, d);
    endtask

    // Offers one beat, with random idle cycles ahead of it, and waits for acceptance.
    task automatic send_item(logic act, logic [W-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.action <= act;
        in_if.value <= val;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_input(act, val);
    endtask

    // Lowers valid and waits until every pending power has come back.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (board.pending_powers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [W-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'd2;
            2: return W'($urandom_range(2, 255));
            3: return W'($urandom_range(0, 1));
            default: return W'($urandom_range(2, 65535));
        endcase
    endfunction

    function automatic logic [W-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return W'($urandom_range(0, 2));
            2: return W'($urandom_range(3, 64));
            default: return W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return board.modulus - 1'b1;
            3: return board.modulus;
            default: return W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Corner cases: exponents of zero and one, zero and unit modulus,
    // values at and above the modulus, full-width keys and a textbook key pair.
    task automatic run_directed();
        send_item(1'b0, 16'd0);
        send_item(1'b1, 16'hFFFF);
        send_item(1'b0, 16'd3);
        drain();
        load_key(16'hFFFF, 16'hFFFF, 16'd2);
        write_reg(CFG_UNUSED, 16'hA5A5);
        send_item(1'b0, 16'd0);
        send_item(1'b0, 16'd1);
        send_item(1'b0, 16'hFFFE);
        send_item(1'b1, 16'hFFFF);
        send_item(1'b1, 16'hFFFE);
        drain();
        load_key(16'd3233, 16'd17, 16'd2753);
        send_item(1'b0, 16'd65);
        send_item(1'b1, 16'd2790);
        drain();
        load_key(16'd0, 16'd5, 16'hFFFF);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b1, 16'd1234);
        drain();
        load_key(16'd1, 16'd2, 16'd0);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b1, 16'd777);
        send_item(1'b0, 16'd0);
        drain();
        load_key(16'd2, 16'd0, 16'd3);
        send_item(1'b0, 16'hFFFF);
        send_item(1'b1, 16'hFFFF);
        send_item(1'b1, 16'd2);
        drain();
        load_key(16'd65521, 16'd3, 16'd3);
        send_item(1'b1, 16'd65520);
        drain();
    endtask

    // Main sequence.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.action = 1'b0;
        in_if.value = '0;
        out_if.ready = 1'b0;
        send_idle = 15;
        recv_idle = 68;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // Random phases: sender idles lightly first, then the receiver, then neither.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < 4) begin
                send_idle = 15;
                recv_idle = 68;
            end else if (ph < 8) begin
                send_idle = 68;
                recv_idle = 15;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_key(pick_modulus(), pick_exponent(), pick_exponent());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(1'($urandom_range(0, 1)), pick_value());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_powers.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
